>>> sv/saturating_signed_alu_assert.svh
// assertion macros shared by the checker
`ifndef SATURATING_SIGNED_ALU_ASSERT_SVH
`define SATURATING_SIGNED_ALU_ASSERT_SVH

// implication checked only outside reset
`define SSALU_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ssalu assertion failed");

// next-cycle implication checked only outside reset
`define SSALU_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ssalu assertion failed");

// implication checked at every edge, reset included
`define SSALU_ASSERT_ANY(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("ssalu assertion failed");

`endif

>>> sv/ssalu_pkg.sv
package ssalu_pkg;

    localparam logic [3:0] FN_AND   = 4'd0;
    localparam logic [3:0] FN_OR    = 4'd1;
    localparam logic [3:0] FN_XOR   = 4'd2;
    localparam logic [3:0] FN_NOT   = 4'd3;
    localparam logic [3:0] FN_ADD   = 4'd4;
    localparam logic [3:0] FN_SUB   = 4'd5;
    localparam logic [3:0] FN_MUL   = 4'd6;
    localparam logic [3:0] FN_DIV   = 4'd7;
    localparam logic [3:0] FN_INC   = 4'd8;
    localparam logic [3:0] FN_DEC   = 4'd9;
    localparam logic [3:0] FN_PASSB = 4'd10;

    // which back-end unit carries the transaction
    typedef enum logic [1:0] {
        CLS_ALU = 2'd0,
        CLS_MUL = 2'd1,
        CLS_DIV = 2'd2
    } t_cls;

    // operands are held sign-extended from the active width
    typedef struct packed {
        logic [3:0]  func;
        t_cls        cls;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic        neg;
    } t_item;

    typedef struct packed {
        logic [63:0] result;
        logic        saturated;
    } t_res;

    // handshake between the classifier queue and the execution side
    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctl;

endpackage

>>> sv/ssalu_front.sv
module ssalu_front #(
    parameter int WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [3:0]           i_func,
    input  logic signed [63:0]   i_operand_a,
    input  logic signed [63:0]   i_operand_b,
    input  logic                 i_pop,
    output logic                 o_valid,
    output ssalu_pkg::t_item     o_item
);

    localparam logic [WIDTH-1:0] VMIN = {1'b1, {(WIDTH-1){1'b0}}};

    logic signed [WIDTH-1:0] w_a;
    logic signed [WIDTH-1:0] w_b;
    logic [WIDTH-1:0]        w_ma;
    logic [WIDTH-1:0]        w_mb;
    ssalu_pkg::t_item        w_item;
    logic                    w_wr;
    logic                    w_rd;

    ssalu_pkg::t_item        r_mem [2];
    logic                    r_wp;
    logic                    r_rp;
    logic [1:0]              r_cnt;

    assign w_a  = i_operand_a[WIDTH-1:0];
    assign w_b  = i_operand_b[WIDTH-1:0];
    assign w_ma = w_a[WIDTH-1] ? (-w_a) : w_a;
    assign w_mb = w_b[WIDTH-1] ? (-w_b) : w_b;

    always_comb begin
        w_item.func = i_func;
        w_item.a    = 64'(w_a);
        w_item.b    = 64'(w_b);
        w_item.ma   = 64'(w_ma);
        w_item.mb   = 64'(w_mb);
        w_item.neg  = w_a[WIDTH-1] ^ w_b[WIDTH-1];
        w_item.cls  = ssalu_pkg::CLS_ALU;
        if (i_func == ssalu_pkg::FN_MUL) begin
            w_item.cls = ssalu_pkg::CLS_MUL;
        end else if (i_func == ssalu_pkg::FN_DIV && w_b != '0
                     && !(w_a == VMIN && w_b == '1)) begin
            // divide by zero and min over -1 stay on the alu path
            w_item.cls = ssalu_pkg::CLS_DIV;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

>>> sv/ssalu_back.sv
module ssalu_back #(
    parameter int WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ssalu_pkg::t_item     i_item,
    input  ssalu_pkg::t_q_ctl    i_q,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic signed [63:0]   o_result,
    output logic                 o_saturated
);

    localparam int H  = (WIDTH + 1) / 2;
    localparam int CW = $clog2(WIDTH + 1);
    localparam logic [WIDTH-1:0] VMAX = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic [WIDTH-1:0] VMIN = {1'b1, {(WIDTH-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_RUN = 3'b001,
        ST_MUL = 3'b010,
        ST_DIV = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic signed [WIDTH-1:0] w_a, w_b, w_s;
    logic [WIDTH-1:0]        w_alu;
    logic                    w_alu_sat;
    logic [2*H-1:0]          w_ma, w_mb;
    logic [4*H-1:0]          w_psum, w_lim;
    logic [WIDTH-1:0]        w_mul;
    logic                    w_mul_sat;
    logic [WIDTH:0]          w_rs;
    logic                    w_ge;
    logic                    w_space, w_push, w_rd;
    ssalu_pkg::t_res         w_res;

    logic [2*H-1:0]   r_pll, r_plh, r_phl, r_phh;
    logic             r_neg;
    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_quo, r_div;
    logic [CW-1:0]    r_dcnt;

    ssalu_pkg::t_res  r_ob [2];
    logic             r_owp, r_orp;
    logic [1:0]       r_ocnt;

    assign w_a = i_item.a[WIDTH-1:0];
    assign w_b = i_item.b[WIDTH-1:0];

    // combinational alu operations
    always_comb begin
        w_alu     = '0;
        w_alu_sat = 1'b0;
        w_s       = '0;
        case (i_item.func)
            ssalu_pkg::FN_AND:   w_alu = w_a & w_b;
            ssalu_pkg::FN_OR:    w_alu = w_a | w_b;
            ssalu_pkg::FN_XOR:   w_alu = w_a ^ w_b;
            ssalu_pkg::FN_NOT:   w_alu = ~w_a;
            ssalu_pkg::FN_ADD: begin
                w_s   = w_a + w_b;
                w_alu = w_s;
                if (w_a[WIDTH-1] == w_b[WIDTH-1] && w_s[WIDTH-1] != w_a[WIDTH-1]) begin
                    w_alu     = w_a[WIDTH-1] ? VMIN : VMAX;
                    w_alu_sat = 1'b1;
                end
            end
            ssalu_pkg::FN_SUB: begin
                w_s   = w_a - w_b;
                w_alu = w_s;
                if (w_a[WIDTH-1] != w_b[WIDTH-1] && w_s[WIDTH-1] != w_a[WIDTH-1]) begin
                    w_alu     = w_a[WIDTH-1] ? VMIN : VMAX;
                    w_alu_sat = 1'b1;
                end
            end
            ssalu_pkg::FN_DIV: begin
                // only the special cases reach here
                w_alu_sat = 1'b1;
                w_alu     = (w_b == '0 && w_a == '0) ? '0 : VMAX;
            end
            ssalu_pkg::FN_INC: begin
                w_alu     = (w_a == VMAX) ? VMAX : WIDTH'(w_a + 1'b1);
                w_alu_sat = (w_a == VMAX);
            end
            ssalu_pkg::FN_DEC: begin
                w_alu     = (w_a == VMIN) ? VMIN : WIDTH'(w_a - 1'b1);
                w_alu_sat = (w_a == VMIN);
            end
            ssalu_pkg::FN_PASSB: w_alu = w_b;
            default: begin
                w_alu     = '0;
                w_alu_sat = 1'b0;
            end
        endcase
    end

    // multiplier: four half-width partial products, registered, then summed and clamped
    assign w_ma   = (2*H)'(i_item.ma[WIDTH-1:0]);
    assign w_mb   = (2*H)'(i_item.mb[WIDTH-1:0]);
    assign w_psum = (4*H)'(r_pll) + ((4*H)'(r_plh) << H) + ((4*H)'(r_phl) << H)
                  + ((4*H)'(r_phh) << (2*H));
    assign w_lim  = r_neg ? (4*H)'(VMIN) : (4*H)'(VMAX);
    assign w_mul_sat = (w_psum > w_lim);
    assign w_mul  = w_mul_sat ? (r_neg ? VMIN : VMAX)
                  : (r_neg ? (-w_psum[WIDTH-1:0]) : w_psum[WIDTH-1:0]);

    // restoring divider, one quotient bit per cycle
    assign w_rs = {r_rem[WIDTH-1:0], r_quo[WIDTH-1]};
    assign w_ge = (w_rs >= {1'b0, r_div});

    assign w_space = (r_ocnt != 2'd2);

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        w_push    = 1'b0;
        w_res     = '0;
        unique case (r_state)
            ST_RUN: begin
                if (i_q.valid) begin
                    case (i_item.cls)
                        ssalu_pkg::CLS_MUL: begin
                            o_q_pop = 1'b1;
                            n_state = ST_MUL;
                        end
                        ssalu_pkg::CLS_DIV: begin
                            o_q_pop = 1'b1;
                            n_state = ST_DIV;
                        end
                        default: begin
                            if (w_space) begin
                                o_q_pop         = 1'b1;
                                w_push          = 1'b1;
                                w_res.result    = 64'(signed'(w_alu));
                                w_res.saturated = w_alu_sat;
                            end
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (w_space) begin
                    w_push          = 1'b1;
                    w_res.result    = 64'(signed'(w_mul));
                    w_res.saturated = w_mul_sat;
                    n_state         = ST_RUN;
                end
            end
            ST_DIV: begin
                if (r_dcnt == '0 && w_space) begin
                    w_push          = 1'b1;
                    w_res.result    = 64'(signed'(r_neg ? (-r_quo) : r_quo));
                    w_res.saturated = 1'b0;
                    n_state         = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && o_q_pop) begin
            r_neg  <= i_item.neg;
            r_pll  <= w_ma[H-1:0] * w_mb[H-1:0];
            r_plh  <= w_ma[H-1:0] * w_mb[2*H-1:H];
            r_phl  <= w_ma[2*H-1:H] * w_mb[H-1:0];
            r_phh  <= w_ma[2*H-1:H] * w_mb[2*H-1:H];
            r_rem  <= '0;
            r_quo  <= i_item.ma[WIDTH-1:0];
            r_div  <= i_item.mb[WIDTH-1:0];
        end else if (r_state == ST_DIV && r_dcnt != '0) begin
            r_rem <= w_ge ? (w_rs - {1'b0, r_div}) : w_rs;
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ob[r_owp] <= w_res;
        end
    end

    assign w_rd        = i_pop && !o_empty;
    assign o_empty     = (r_ocnt == 2'd0);
    assign o_result    = r_ob[r_orp].result;
    assign o_saturated = r_ob[r_orp].saturated;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_dcnt  <= '0;
            r_owp   <= 1'b0;
            r_orp   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN && o_q_pop) begin
                r_dcnt <= CW'(WIDTH);
            end else if (r_state == ST_DIV && r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
            end
            if (w_push) r_owp <= ~r_owp;
            if (w_rd)   r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(w_push) - 2'(w_rd);
        end
    end

endmodule

>>> sv/saturating_signed_alu.sv
// saturating signed alu
// input channel: a transaction (i_func, i_operand_a, i_operand_b) is taken at a
//   rising edge with push high and full low; only the low WIDTH bits of each
//   operand are used, read as two's complement
// result channel: while empty is low the oldest result sits on o_result and
//   o_saturated; it is taken at a rising edge with pop high
// front end classifies each transaction and parks it in a two-entry queue;
//   the back end executes in order and writes a two-entry result queue
// logic, add/sub, inc/dec, pass and divide special cases are computed
//   combinationally and written to the result queue as they leave the input
//   queue; one transaction per cycle for these while the result queue has space
// multiply holds the execution side through partial products, then sum and
//   clamp; divide holds it through load, WIDTH restoring steps and write out;
//   neither lets a new transaction in until its result is written
// reset empties both queues and returns the back end to its run state
// a stalled receiver fills the result queue, then the back end waits and the
//   input queue fills until full rises; nothing is dropped
module saturating_signed_alu #(
    parameter int WIDTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [3:0]          i_func,
    input  logic signed [63:0]  i_operand_a,
    input  logic signed [63:0]  i_operand_b,
    output logic                empty,
    input  logic                pop,
    output logic signed [63:0]  o_result,
    output logic                o_saturated
);

    // queue between classifier and execution
    ssalu_pkg::t_item  w_item;
    ssalu_pkg::t_q_ctl w_q;
    logic              w_pop;

    assign w_q.pop = w_pop;

    ssalu_front #(.WIDTH(WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_pop       (w_q.pop),
        .o_valid     (w_q.valid),
        .o_item      (w_item)
    );

    // execution: combinational alu, split multiplier, serial divider
    ssalu_back #(.WIDTH(WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_q         (w_q),
        .o_q_pop     (w_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result),
        .o_saturated (o_saturated)
    );

endmodule

>>> sv/ssalu_checker.sv
`include "saturating_signed_alu_assert.svh"

module ssalu_checker #(
    parameter int WIDTH = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic signed [63:0] o_result,
    input logic               o_saturated
);

    localparam logic signed [WIDTH-1:0] VMAX = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic signed [WIDTH-1:0] VMIN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [63:0] XMAX = 64'(VMAX);
    localparam logic [63:0] XMIN = 64'(VMIN);

    logic w_ext_ok;
    assign w_ext_ok = (o_result == 64'(signed'(o_result[WIDTH-1:0])));

    // after a reset cycle the result queue is empty and the input queue is not full
    `SSALU_ASSERT_ANY(a_rst_empty, i_clk, !$past(i_rst_n), empty && !full)

    // a clamped result is always a limit or zero
    `SSALU_ASSERT_IMP(a_sat_val, i_clk, i_rst_n, !empty && o_saturated,
        o_result == XMAX || o_result == XMIN || o_result == 64'd0)

    // results are sign-extended from the active width
    `SSALU_ASSERT_IMP(a_sext, i_clk, i_rst_n, !empty, w_ext_ok)

    // an unread result holds
    `SSALU_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_result) && $stable(o_saturated))

endmodule

bind saturating_signed_alu ssalu_checker #(.WIDTH(WIDTH)) u_ssalu_checker (.*);

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    // opcodes above the last defined one decode to nothing
    localparam logic [3:0] FN_SPARE_LO = ssalu_pkg::FN_PASSB + 4'd1;
    localparam logic [3:0] FN_SPARE_HI = 4'd15;
    localparam int RANDOM_ITEMS = 1200;
    localparam int SETTLE_CYCLES = 80;   // longest op is a divide

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [3:0]         i_func;
    logic signed [63:0] i_operand_a;
    logic signed [63:0] i_operand_b;
    logic               empty;
    logic               pop;
    logic signed [63:0] o_result;
    logic               o_saturated;

    saturating_signed_alu uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .o_saturated (o_saturated)
    );

    // results still owed by the alu, oldest first
    ssalu_pkg::t_res alu_results_due[$];
    int   mismatch_count = 0;

    // receiver and sender control: a forced receiver hold-off and no-idle windows
    int   rx_hold_cycles = 0;
    bit   rx_no_idle = 0;
    bit   tx_no_idle = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("saturating_signed_alu test failed");
        $finish;
    end

    // expected result of one transaction, full-width signed arithmetic
    function automatic ssalu_pkg::t_res alu_expect(logic [3:0] fn, logic signed [63:0] a,
                                                   logic signed [63:0] b);
        ssalu_pkg::t_res     r;
        logic signed [64:0]  wide_sum;
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        r.result = '0;
        r.saturated = 1'b0;
        wa = a;
        wb = b;
        case (fn)
            ssalu_pkg::FN_AND: r.result = a & b;
            ssalu_pkg::FN_OR:  r.result = a | b;
            ssalu_pkg::FN_XOR: r.result = a ^ b;
            ssalu_pkg::FN_NOT: r.result = ~a;
            ssalu_pkg::FN_ADD, ssalu_pkg::FN_SUB: begin
                wide_sum = (fn == ssalu_pkg::FN_ADD) ? (65'(a) + 65'(b))
                                                     : (65'(a) - 65'(b));
                if (wide_sum > 65'(S64_MAX)) begin
                    r.result = S64_MAX;
                    r.saturated = 1'b1;
                end else if (wide_sum < 65'(S64_MIN)) begin
                    r.result = S64_MIN;
                    r.saturated = 1'b1;
                end else begin
                    r.result = wide_sum[63:0];
                end
            end
            ssalu_pkg::FN_MUL: begin
                prod = wa * wb;
                if (prod > 128'(S64_MAX)) begin
                    r.result = S64_MAX;
                    r.saturated = 1'b1;
                end else if (prod < 128'(S64_MIN)) begin
                    r.result = S64_MIN;
                    r.saturated = 1'b1;
                end else begin
                    r.result = prod[63:0];
                end
            end
            ssalu_pkg::FN_DIV: begin
                if (b == 0) begin
                    // zero over zero gives zero, anything else the maximum
                    r.result = (a == 0) ? 64'sd0 : S64_MAX;
                    r.saturated = 1'b1;
                end else if (a == S64_MIN && b == -64'sd1) begin
                    r.result = S64_MAX;
                    r.saturated = 1'b1;
                end else begin
                    r.result = a / b;   // truncates toward zero
                end
            end
            ssalu_pkg::FN_INC: begin
                if (a == S64_MAX) begin
                    r.result = a;
                    r.saturated = 1'b1;
                end else begin
                    r.result = a + 64'sd1;
                end
            end
            ssalu_pkg::FN_DEC: begin
                if (a == S64_MIN) begin
                    r.result = a;
                    r.saturated = 1'b1;
                end else begin
                    r.result = a - 64'sd1;
                end
            end
            ssalu_pkg::FN_PASSB: r.result = b;
            default: ;
        endcase
        return r;
    endfunction

    // offer one transaction from the falling edge until it is taken
    task automatic send_op(logic [3:0] fn, logic signed [63:0] a, logic signed [63:0] b);
        int gap;
        @(negedge i_clk);
        push <= 1'b1;
        i_func <= fn;
        i_operand_a <= a;
        i_operand_b <= b;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        alu_results_due.push_back(alu_expect(fn, a, b));
        // sender gap: mostly none, sometimes short, rarely long
        gap = 0;
        if (!tx_no_idle) begin
            case ($urandom_range(0, 19))
                0, 1, 2: gap = $urandom_range(1, 3);
                3:       gap = $urandom_range(10, 40);
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic lower_push();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    // operand mix: edges, small values, mid-size for the multiply boundary, full random
    function automatic logic signed [63:0] pick_operand();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: return S64_MAX;
                    1: return S64_MIN;
                    2: return 64'sd0;
                    3: return -64'sd1;
                    4: return 64'sd1;
                    default: return S64_MIN + 64'sd1;
                endcase
            end
            1, 2: return 64'($signed($urandom_range(0, 200)) - 100);
            3, 4: return $signed({{32{1'b0}}, 32'($urandom)})
                         * (($urandom_range(0, 1) != 0) ? 64'sd1 : -64'sd1);
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [3:0] pick_func();
        // unused opcodes show up now and then
        if ($urandom_range(0, 15) == 0)
            return 4'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        return 4'($urandom_range(ssalu_pkg::FN_AND, ssalu_pkg::FN_PASSB));
    endfunction

    task automatic wait_results_drained();
        wait (alu_results_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result checker: compare each popped transaction with the oldest expectation
    always @(posedge i_clk) begin
        ssalu_pkg::t_res want;
        if (i_rst_n && pop && !empty) begin
            if (alu_results_due.size() == 0) begin
                $display("%0t: unexpected result, actual result=%h saturated=%b",
                         $time, o_result, o_saturated);
                mismatch_count++;
            end else begin
                want = alu_results_due.pop_front();
                if (o_result !== want.result) begin
                    $display("%0t: result mismatch, expected %h actual %h",
                             $time, want.result, o_result);
                    mismatch_count++;
                end
                if (o_saturated !== want.saturated) begin
                    $display("%0t: saturated mismatch, expected %b actual %b",
                             $time, want.saturated, o_saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random pops, plus a forced hold-off counted here in cycles
    initial begin
        int stall;
        stall = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                pop <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                if (!rx_no_idle) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2: stall = $urandom_range(1, 3);
                        3:       stall = $urandom_range(10, 40);
                        default: stall = 0;
                    endcase
                end
            end
        end
    end

    // logic ops, not, pass b and the unused opcodes, mostly at the operand extremes
    task automatic test_bitwise_ops();
        send_op(ssalu_pkg::FN_AND, S64_MAX, S64_MIN);
        send_op(ssalu_pkg::FN_AND, -64'sd1, 64'sh5555_aaaa_0f0f_f0f0);
        send_op(ssalu_pkg::FN_OR, S64_MIN, 64'sd1);
        send_op(ssalu_pkg::FN_XOR, -64'sd1, S64_MAX);
        send_op(ssalu_pkg::FN_NOT, 64'sd0, 64'sd7);
        send_op(ssalu_pkg::FN_NOT, S64_MIN, 64'sd0);
        send_op(ssalu_pkg::FN_PASSB, 64'sd3, S64_MIN);
        send_op(FN_SPARE_LO, -64'sd1, -64'sd1);
        send_op(FN_SPARE_HI, S64_MAX, S64_MAX);
    endtask

    // overflow and clamping corners of the arithmetic ops
    task automatic test_saturation_corners();
        send_op(ssalu_pkg::FN_ADD, S64_MAX, 64'sd1);           // clamps high
        send_op(ssalu_pkg::FN_ADD, S64_MIN, -64'sd1);          // clamps low
        send_op(ssalu_pkg::FN_ADD, 64'sd3, -64'sd4);
        send_op(ssalu_pkg::FN_SUB, S64_MIN, 64'sd1);
        send_op(ssalu_pkg::FN_SUB, S64_MAX, -64'sd1);
        send_op(ssalu_pkg::FN_MUL, S64_MAX, 64'sd2);
        send_op(ssalu_pkg::FN_MUL, S64_MIN, -64'sd1);  // positive overflow from two negatives
        send_op(ssalu_pkg::FN_MUL, S64_MIN, 64'sd1);           // exact minimum, no clamp
        send_op(ssalu_pkg::FN_MUL, -64'sd3, 64'sh4000_0000_0000_0000); // negative overflow
        send_op(ssalu_pkg::FN_DIV, 64'sd5, 64'sd0);
        send_op(ssalu_pkg::FN_DIV, -64'sd5, 64'sd0);
        send_op(ssalu_pkg::FN_DIV, 64'sd0, 64'sd0);
        send_op(ssalu_pkg::FN_DIV, S64_MIN, -64'sd1);
        send_op(ssalu_pkg::FN_DIV, -64'sd7, 64'sd2);           // truncates toward zero
        send_op(ssalu_pkg::FN_INC, S64_MAX, 64'sd0);
        send_op(ssalu_pkg::FN_DEC, S64_MIN, 64'sd0);
        send_op(ssalu_pkg::FN_INC, -64'sd1, 64'sd9);
    endtask

    task automatic test_random_mix(int count);
        for (int n = 0; n < count; n++)
            send_op(pick_func(), pick_operand(), pick_operand());
    endtask

    // receiver holds off while the sender keeps offering, so full must rise
    task automatic test_full_backpressure();
        tx_no_idle = 1;
        rx_hold_cycles = 60;
        for (int n = 0; n < 20; n++)
            send_op(4'($urandom_range(ssalu_pkg::FN_AND, ssalu_pkg::FN_MUL)),
                    pick_operand(), pick_operand());
        tx_no_idle = 0;
    endtask

    // back-to-back traffic with nobody idling
    task automatic test_streaming();
        tx_no_idle = 1;
        rx_no_idle = 1;
        test_random_mix(40);
        tx_no_idle = 0;
        rx_no_idle = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_func = ssalu_pkg::FN_AND;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_bitwise_ops();
        test_saturation_corners();
        test_full_backpressure();
        lower_push();
        // sender waits until everything owed has come back
        wait_results_drained();
        test_streaming();
        test_random_mix(RANDOM_ITEMS);
        lower_push();

        wait_results_drained();
        if (mismatch_count == 0) begin
            $display("saturating_signed_alu test passed");
        end else begin
            $display("saturating_signed_alu test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/ssalu_pkg.sv
sv/ssalu_front.sv
sv/ssalu_back.sv
sv/saturating_signed_alu.sv
sv/ssalu_checker.sv
sim/tb_top.sv
